FILE: hw/rtl/ptlmv_pkg.sv
// Package with shared types and constants for the label vote block.
`timescale 1ns / 1ps
package ptlmv_pkg;
  localparam int TRACK_SLOTS = 256;
  localparam int MAX_DEPTH = 16;
  localparam int SLOT_W = $clog2(TRACK_SLOTS);
  localparam int POS_W = $clog2(MAX_DEPTH);
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W = SLOT_W + POS_W;
  localparam int ENTRY_W = 64;
  localparam logic [31:0] UNKNOWN_COLOR = 32'hFF0000FF;
  localparam logic [4:0] RESET_MAX_RECORDS = 5'd10;

  typedef struct packed {
    logic [7:0] track_id;
    logic has_label;
    logic [15:0] label_class;
    logic [15:0] label_confidence;
    logic [31:0] label_color;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] top_class;
    logic [15:0] top_confidence;
    logic [31:0] top_color;
    logic is_unknown;
    logic id_error;
  } out_beat_t;

  // Job passed from the front to the back part.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0] oldest;
    logic [CNT_W-1:0] cnt;
    logic id_error;
  } job_t;

  typedef enum logic [1:0] {
    FR_CLEAR,
    FR_IDLE,
    FR_LOOK
  } fr_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_OUTER,
    BK_INNER,
    BK_FETCH,
    BK_DONE
  } bk_state_t;
endpackage

FILE: hw/rtl/ptlmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ptlmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hw/rtl/ptlmv_front.sv
// Front part: accepts beats, updates ring pointers and writes new labels.
`timescale 1ns / 1ps
module ptlmv_front (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic in_valid,
  output logic in_stall,
  input  ptlmv_pkg::in_beat_t in_data,
  output logic job_valid,
  input  logic job_stall,
  output ptlmv_pkg::job_t job,
  input  logic vote_busy,
  input  logic [ptlmv_pkg::SLOT_W-1:0] vote_slot,
  output logic wr_en,
  output logic [ptlmv_pkg::ADDR_W-1:0] wr_addr,
  output logic [ptlmv_pkg::ENTRY_W-1:0] wr_data
);
  import ptlmv_pkg::*;

  fr_state_t state_r, state_nxt;
  logic [4:0] max_records_r;
  logic [SLOT_W-1:0] clr_idx_r;
  logic job_valid_r;
  job_t job_r;
  logic accept;
  logic in_range;
  logic hazard;
  logic look_ok;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0] lim, cnt_cur, cnt_nxt;
  logic [POS_W-1:0] head_cur, head_nxt;
  logic meta_wr_en;
  logic [SLOT_W-1:0] meta_wr_addr;
  logic [CNT_W+POS_W-1:0] meta_wr_data, meta_rd_data;

  // Per-object count and head, read in the cycle after the beat is offered.
  ptlmv_ram #(.WIDTH(CNT_W + POS_W), .DEPTH(TRACK_SLOTS)) u_meta (
    .clk, .wr_en(meta_wr_en), .wr_addr(meta_wr_addr), .wr_data(meta_wr_data),
    .rd_addr(slot), .rd_data(meta_rd_data)
  );

  assign in_range = ({24'd0, in_data.track_id} < 32'(TRACK_SLOTS));
  assign slot = SLOT_W'(in_data.track_id);
  assign {cnt_cur, head_cur} = meta_rd_data;

  // A new label must not overwrite an entry that a pending or running vote still reads.
  assign hazard = in_data.has_label &&
                  ((job_valid_r && job_r.slot == slot) || (vote_busy && vote_slot == slot));
  assign look_ok = !(job_valid_r && job_stall) && !hazard;
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_CLEAR: begin
        if (clr_idx_r == SLOT_W'(TRACK_SLOTS - 1)) begin
          state_nxt = FR_IDLE;
        end
      end
      FR_IDLE: begin
        if (in_valid) begin
          state_nxt = FR_LOOK;
        end
      end
      FR_LOOK: begin
        if (accept) begin
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    meta_wr_en = 1'b0;
    meta_wr_addr = slot;
    meta_wr_data = {cnt_nxt, head_nxt};
    unique case (state_r)
      FR_CLEAR: begin
        meta_wr_en = 1'b1;
        meta_wr_addr = clr_idx_r;
        meta_wr_data = '0;
      end
      FR_LOOK: begin
        in_stall = !look_ok;
        meta_wr_en = in_valid && look_ok && in_range && in_data.has_label;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (max_records_r == 5'd0) begin
      lim = CNT_W'(1);
    end else if ({27'd0, max_records_r} > 32'(MAX_DEPTH)) begin
      lim = CNT_W'(MAX_DEPTH);
    end else begin
      lim = CNT_W'(max_records_r);
    end
    head_nxt = head_cur;
    cnt_nxt = cnt_cur;
    if (in_data.has_label) begin
      head_nxt = head_cur + POS_W'(1);
      if (cnt_cur < CNT_W'(MAX_DEPTH)) begin
        cnt_nxt = cnt_cur + CNT_W'(1);
      end
      if (cnt_nxt > lim) begin
        cnt_nxt = lim;
      end
    end
  end

  assign wr_en = accept && in_range && in_data.has_label;
  assign wr_addr = {slot, head_cur};
  assign wr_data = {in_data.label_color, in_data.label_confidence, in_data.label_class};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_CLEAR;
      clr_idx_r <= '0;
      max_records_r <= RESET_MAX_RECORDS;
      job_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FR_CLEAR) begin
        clr_idx_r <= clr_idx_r + SLOT_W'(1);
      end
      if (cfg_wr_en) begin
        max_records_r <= cfg_wr_data;
      end
      if (accept) begin
        job_valid_r <= 1'b1;
      end else if (!job_stall) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r.slot <= slot;
      job_r.cnt <= in_range ? cnt_nxt : '0;
      job_r.oldest <= head_nxt - POS_W'(cnt_nxt);
      job_r.id_error <= !in_range;
    end
  end

  assign job_valid = job_valid_r;
  assign job = job_r;
endmodule

FILE: hw/rtl/ptlmv_back.sv
// Back part: walks one history through the RAM and votes on the winner.
`timescale 1ns / 1ps
module ptlmv_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_stall,
  input  ptlmv_pkg::job_t job,
  output logic vote_busy,
  output logic [ptlmv_pkg::SLOT_W-1:0] vote_slot,
  output logic [ptlmv_pkg::ADDR_W-1:0] rd_addr,
  input  logic [ptlmv_pkg::ENTRY_W-1:0] rd_data,
  output logic out_valid,
  input  logic out_stall,
  output ptlmv_pkg::out_beat_t out_data
);
  import ptlmv_pkg::*;

  bk_state_t state_r, state_nxt;
  job_t job_r;
  logic [CNT_W-1:0] i_r, j_r;
  logic [CNT_W-1:0] n_r, best_r;
  logic [15:0] ci_r;
  logic [POS_W-1:0] win_r;
  logic out_valid_r;
  out_beat_t out_r;
  logic [POS_W-1:0] pos;
  logic take;

  // Read address: position i or j of the ring, or the winning entry for the result.
  always_comb begin
    unique case (state_r) inside
      BK_OUTER: pos = job_r.oldest + POS_W'(i_r);
      BK_INNER: pos = job_r.oldest + POS_W'(j_r);
      BK_FETCH, BK_DONE: pos = win_r;
      default:  pos = job_r.oldest;
    endcase
  end
  assign rd_addr = {job_r.slot, pos};

  assign take = job_valid && (state_r == BK_IDLE);
  assign job_stall = !take;
  assign vote_busy = (state_r != BK_IDLE);
  assign vote_slot = job_r.slot;

  // One memory read per cycle; read data lands in the cycle after, tracked by phase flags.
  logic rdv_r;
  logic rd_outer_r;
  logic [CNT_W-1:0] n_fin;

  assign n_fin = (rdv_r && !rd_outer_r && rd_data[15:0] == ci_r) ? n_r + CNT_W'(1) : n_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          state_nxt = (job.cnt == '0) ? BK_DONE : BK_OUTER;
        end
      end
      BK_OUTER: state_nxt = BK_INNER;
      BK_INNER: begin
        if (j_r >= job_r.cnt) begin
          state_nxt = (i_r + CNT_W'(1) >= job_r.cnt) ? BK_FETCH : BK_OUTER;
        end
      end
      BK_FETCH: state_nxt = BK_DONE;
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      out_valid_r <= 1'b0;
      rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r <= (state_r == BK_OUTER) || (state_r == BK_INNER && j_r < job_r.cnt);
      if (state_r == BK_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_outer_r <= (state_r == BK_OUTER);
    if (take) begin
      job_r <= job;
      i_r <= '0;
      best_r <= '0;
      win_r <= job.oldest;
    end
    if (state_r == BK_OUTER) begin
      j_r <= i_r + CNT_W'(1);
      n_r <= '0;
    end
    if (state_r == BK_INNER) begin
      if (j_r < job_r.cnt) begin
        j_r <= j_r + CNT_W'(1);
      end else begin
        i_r <= i_r + CNT_W'(1);
      end
    end
    // Capture the class of entry i.
    if (rdv_r && rd_outer_r) begin
      ci_r <= rd_data[15:0];
    end
    if (rdv_r && !rd_outer_r) begin
      n_r <= n_fin;
    end
    // Close entry i in the cycle its last comparison lands.
    if (state_r == BK_INNER && j_r >= job_r.cnt) begin
      if (n_fin >= best_r) begin
        best_r <= n_fin;
        win_r <= job_r.oldest + POS_W'(i_r);
      end
    end
    if (state_r == BK_DONE && (!out_valid_r || !out_stall)) begin
      if (job_r.cnt == '0) begin
        out_r <= '{16'd0, 16'd0, UNKNOWN_COLOR, 1'b1, job_r.id_error};
      end else begin
        out_r <= '{rd_data[15:0], rd_data[31:16], rd_data[63:32], 1'b0, 1'b0};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_err_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.id_error |-> out_data.is_unknown)
    else $error("id error without unknown");
  a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> state_r != BK_IDLE)
    else $error("job taken but back part idle");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> job_r.cnt <= CNT_W'(MAX_DEPTH))
    else $error("history count beyond depth");
`endif
endmodule

FILE: hw/rtl/per_track_label_majority_vote_top.sv
// Top level of the per-track label majority vote block.
// Channel | Ports                          | Direction
// in      | in_valid, in_stall, in_data    | item in
// out     | out_valid, out_stall, out_data | result out
// cfg     | cfg_wr_en, cfg_wr_data         | max_records write
// The back part compares each stored entry of an item with every later entry;
// its time is set by the single read port of the history RAM, one entry a cycle.
// The front part accepts the next beat while the back part votes, unless that
// beat adds a label to the object being voted on.
// After reset a clearing pass zeroes counts and heads of all 256 slots; in_stall is high.
// A stalled output holds its beat; the back part waits until it is taken.
`timescale 1ns / 1ps
module per_track_label_majority_vote_top (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic in_valid,
  output logic in_stall,
  input  ptlmv_pkg::in_beat_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output ptlmv_pkg::out_beat_t out_data
);
  import ptlmv_pkg::*;

  logic job_valid, job_stall;
  job_t job;
  logic vote_busy;
  logic [SLOT_W-1:0] vote_slot;
  logic wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;

  ptlmv_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall, .in_data,
    .job_valid, .job_stall, .job, .vote_busy, .vote_slot, .wr_en, .wr_addr, .wr_data
  );

  ptlmv_ram #(.WIDTH(ENTRY_W), .DEPTH(TRACK_SLOTS * MAX_DEPTH)) u_ram (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  ptlmv_back u_back (
    .clk, .rst_n, .job_valid, .job_stall, .job, .vote_busy, .vote_slot, .rd_addr, .rd_data,
    .out_valid, .out_stall, .out_data
  );
endmodule
